>>> hdl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

    typedef enum logic [2:0] {
        CMD_ALLOC       = 3'd0,
        CMD_LOOKUP      = 3'd1,
        CMD_FREE        = 3'd2,
        CMD_CLOSE_TREE  = 3'd3,
        CMD_CLOSE_ALL   = 3'd4,
        CMD_SET_RELATED = 3'd5
    } cmd_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam int ENTRY_W = 65;

    typedef struct packed {
        logic        valid;
        logic [31:0] generation;
        logic [31:0] tree;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  slot;
        logic [63:0] handle_high;
        logic [31:0] entry_tree;
        logic [6:0]  closed_count;
    } result_t;

endpackage

>>> hdl/ght_if.sv
`timescale 1ns / 1ps

interface ght_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [63:0] file_id_high;
    logic [63:0] file_id_low;
    logic [31:0] tree_id;

    modport source (output valid, output cmd, output file_id_high, output file_id_low,
                    output tree_id, input ready);
    modport sink (input valid, input cmd, input file_id_high, input file_id_low,
                  input tree_id, output ready);
endinterface

interface ght_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  slot;
    logic [63:0] handle_high;
    logic [31:0] entry_tree;
    logic [6:0]  closed_count;

    modport source (output valid, output status, output slot, output handle_high,
                    output entry_tree, output closed_count, input ready);
    modport sink (input valid, input status, input slot, input handle_high,
                  input entry_tree, input closed_count, output ready);
endinterface

>>> hdl/ght_ram.sv
`timescale 1ns / 1ps

module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ght_out_reg.sv
`timescale 1ns / 1ps

module ght_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  ght_pkg::result_t res,
    output logic             res_ready,
    ght_out_if.source        out_ch
);

    logic             valid_reg;
    ght_pkg::result_t data_reg;

    assign res_ready = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.status       = data_reg.status;
    assign out_ch.slot         = data_reg.slot;
    assign out_ch.handle_high  = data_reg.handle_high;
    assign out_ch.entry_tree   = data_reg.entry_tree;
    assign out_ch.closed_count = data_reg.closed_count;

endmodule

>>> hdl/ght_ctrl.sv
`timescale 1ns / 1ps

module ght_ctrl #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    ght_in_if.sink                                            in_ch,
    output logic                                              mem_we,
    output logic [$clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2)-1:0] mem_waddr,
    output logic [ght_pkg::ENTRY_W-1:0]                       mem_wdata,
    output logic [$clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2)-1:0] mem_raddr,
    input  logic [ght_pkg::ENTRY_W-1:0]                       mem_rdata,
    output logic                                              res_valid,
    output ght_pkg::result_t                                  res,
    input  logic                                              res_ready
);

    localparam int AW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);
    localparam logic [31:0] NUM_ENTRIES = 32'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [63:0]      hi_reg, hi_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [31:0]      tree_reg, tree_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      gen_cnt_reg, gen_cnt_next;
    logic             rel_valid_reg, rel_valid_next;
    logic [63:0]      rel_hi_reg, rel_hi_next;
    logic [63:0]      rel_lo_reg, rel_lo_next;
    logic [AW-1:0]    clr_reg, clr_next;
    ght_pkg::result_t res_reg, res_next;

    ght_pkg::entry_t  rd_entry;
    ght_pkg::entry_t  wr_entry;
    logic             compound;
    logic [63:0]      eff_hi;
    logic [63:0]      eff_lo;
    logic [31:0]      idx;
    logic [31:0]      idx_m1;
    logic             id_ok;
    logic [AW:0]      addr_slot;
    logic [AW:0]      pend_slot;
    logic [63:0]      pend_handle;
    logic [31:0]      gen_new;
    logic             hit;
    logic             accept;

    assign rd_entry    = ght_pkg::entry_t'(mem_rdata);
    assign compound    = (in_ch.file_id_high == '1) && (in_ch.file_id_low == '1);
    assign eff_hi      = compound ? rel_hi_reg : in_ch.file_id_high;
    assign eff_lo      = compound ? rel_lo_reg : in_ch.file_id_low;
    assign idx         = eff_hi[63:32];
    assign idx_m1      = idx - 32'd1;
    assign id_ok       = (!compound || rel_valid_reg) && (eff_lo == 64'd0) &&
                         (idx != 32'd0) && (idx <= NUM_ENTRIES);
    assign addr_slot   = {1'b0, addr_reg} + (AW+1)'(1);
    assign pend_slot   = {1'b0, pend_addr_reg} + (AW+1)'(1);
    assign pend_handle = {32'(pend_slot), rd_entry.generation};
    assign gen_new     = gen_cnt_reg + 32'd1;
    assign hit         = rd_entry.valid &&
                         ((cmd_reg == ght_pkg::CMD_CLOSE_ALL) || (rd_entry.tree == tree_reg));
    assign accept      = in_ch.valid && in_ch.ready;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res         = res_reg;
    assign mem_wdata   = wr_entry;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        hi_next        = hi_reg;
        addr_next      = addr_reg;
        tree_next      = tree_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        gen_cnt_next   = gen_cnt_reg;
        rel_valid_next = rel_valid_reg;
        rel_hi_next    = rel_hi_reg;
        rel_lo_next    = rel_lo_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        wr_entry       = '0;
        mem_raddr      = ptr_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                mem_raddr = idx_m1[AW-1:0];
                if (accept)
                begin
                    cmd_next       = in_ch.cmd;
                    hi_next        = eff_hi;
                    addr_next      = idx_m1[AW-1:0];
                    tree_next      = in_ch.tree_id;
                    ptr_next       = '0;
                    pend_next      = 1'b0;
                    count_next     = '0;
                    res_next       = '0;
                    case (in_ch.cmd)
                        ght_pkg::CMD_ALLOC,
                        ght_pkg::CMD_CLOSE_TREE,
                        ght_pkg::CMD_CLOSE_ALL:
                        begin
                            state_next = S_SCAN;
                        end
                        ght_pkg::CMD_LOOKUP,
                        ght_pkg::CMD_FREE:
                        begin
                            if (id_ok)
                            begin
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                res_next.status = ght_pkg::STATUS_NOT_FOUND;
                                state_next      = S_DONE;
                            end
                        end
                        ght_pkg::CMD_SET_RELATED:
                        begin
                            rel_valid_next = 1'b1;
                            rel_hi_next    = in_ch.file_id_high;
                            rel_lo_next    = in_ch.file_id_low;
                            state_next     = S_DONE;
                        end
                        default:
                        begin
                            res_next.status = ght_pkg::STATUS_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (rd_entry.valid && (rd_entry.generation == hi_reg[31:0]))
                begin
                    res_next.status      = ght_pkg::STATUS_OK;
                    res_next.slot        = 7'(addr_slot);
                    res_next.handle_high = hi_reg;
                    res_next.entry_tree  = rd_entry.tree;
                    if (cmd_reg == ght_pkg::CMD_FREE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_reg;
                        if (rel_valid_reg && (rel_hi_reg == hi_reg) && (rel_lo_reg == 64'd0))
                        begin
                            rel_valid_next = 1'b0;
                            rel_hi_next    = '0;
                            rel_lo_next    = '0;
                        end
                    end
                end
                else
                begin
                    res_next.status = ght_pkg::STATUS_NOT_FOUND;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                ptr_next       = ptr_reg + AW'(1);
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg;
                if (pend_reg)
                begin
                    if (cmd_reg == ght_pkg::CMD_ALLOC)
                    begin
                        if (!rd_entry.valid)
                        begin
                            mem_we              = 1'b1;
                            wr_entry.valid      = 1'b1;
                            wr_entry.generation = gen_new;
                            wr_entry.tree       = tree_reg;
                            gen_cnt_next        = gen_new;
                            res_next.status     = ght_pkg::STATUS_OK;
                            res_next.slot       = 7'(pend_slot);
                            res_next.handle_high = {32'(pend_slot), gen_new};
                            res_next.entry_tree = tree_reg;
                            state_next          = S_DONE;
                        end
                        else if (pend_addr_reg == LAST)
                        begin
                            res_next.status = ght_pkg::STATUS_FULL;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (rel_valid_reg && (rel_hi_reg == pend_handle) &&
                                (rel_lo_reg == 64'd0))
                            begin
                                rel_valid_next = 1'b0;
                                rel_hi_next    = '0;
                                rel_lo_next    = '0;
                            end
                        end
                        if (pend_addr_reg == LAST)
                        begin
                            res_next.status       = ght_pkg::STATUS_OK;
                            res_next.closed_count = 7'(count_next);
                            state_next            = S_DONE;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmd_reg       <= '0;
            hi_reg        <= '0;
            addr_reg      <= '0;
            tree_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            count_reg     <= '0;
            gen_cnt_reg   <= '0;
            rel_valid_reg <= 1'b0;
            rel_hi_reg    <= '0;
            rel_lo_reg    <= '0;
            clr_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            hi_reg        <= hi_next;
            addr_reg      <= addr_next;
            tree_reg      <= tree_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            count_reg     <= count_next;
            gen_cnt_reg   <= gen_cnt_next;
            rel_valid_reg <= rel_valid_next;
            rel_hi_reg    <= rel_hi_next;
            rel_lo_reg    <= rel_lo_next;
            clr_reg       <= clr_next;
            res_reg       <= res_next;
        end
    end

endmodule

>>> hdl/generation_handle_table_unit.sv
`timescale 1ns / 1ps

// Handle table with generation-tagged ids.
// Channels: in_ch carries one command beat (cmd, file_id_high, file_id_low,
// tree_id); out_ch returns exactly one result beat per command, in order.
// The table sits in one single-port-write RAM of TABLE_ENTRIES words
// (valid, generation, tree) with a registered read.
// Lookup and free take one RAM read and one check; set related, a bad id
// and a bad command code answer without touching the table; alloc scans
// upward to the lowest free slot, while a full-table alloc and close
// tree/all scan every word (one RAM word per cycle).
// One command is in flight at a time; in_ch.ready rises at the clock edge
// that moves the result into the output register.
// After reset a clearing pass writes every word with in_ch.ready low; the
// generation counter and related id reset to zero.
// While out_ch stalls the next command is accepted and run; its result waits
// until the output register is taken.
module generation_handle_table_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ght_in_if.sink    in_ch,
    ght_out_if.source out_ch
);

    localparam int AW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [ght_pkg::ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [ght_pkg::ENTRY_W-1:0] mem_rdata;
    logic                        res_valid;
    logic                        res_ready;
    ght_pkg::result_t            res;

    ght_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    ght_ram #(
        .WIDTH (ght_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ght_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_ch    (out_ch)
    );

endmodule
